>>> design/pfc_pkg.sv
// Shared codes, defaults and payload types of the PID filter table.
package pfc_pkg;

  // Default number of table slots.
  localparam int unsigned NUM_SLOTS_DEF = 32;

  // Field widths.
  localparam int unsigned OP_W  = 3;
  localparam int unsigned PID_W = 13;
  localparam int unsigned MK_W  = 2;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned RC_W  = 2;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL     = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_ALL = 3'd2;
  localparam logic [OP_W-1:0] OP_SETTLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_TUNING  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLOSE   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

  // Slot marks.
  localparam logic [MK_W-1:0] MK_VALID = 2'd0;
  localparam logic [MK_W-1:0] MK_FREE  = 2'd1;
  localparam logic [MK_W-1:0] MK_ADD   = 2'd2;
  localparam logic [MK_W-1:0] MK_DEL   = 2'd3;

  // Session status codes.
  localparam logic [ST_W-1:0] ST_INCOMPLETE = 3'd0;
  localparam logic [ST_W-1:0] ST_SETTLED    = 3'd1;
  localparam logic [ST_W-1:0] ST_TUNING     = 3'd2;
  localparam logic [ST_W-1:0] ST_PIDS       = 3'd3;
  localparam logic [ST_W-1:0] ST_CLOSING    = 3'd4;

  // Result codes.
  localparam logic [RC_W-1:0] RC_OK       = 2'd0;
  localparam logic [RC_W-1:0] RC_NOCHANGE = 2'd1;
  localparam logic [RC_W-1:0] RC_ERROR    = 2'd2;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [PID_W-1:0] pid_value;
  } pfc_in_t;

  // Result item.
  typedef struct packed {
    logic [RC_W-1:0] result_code;
    logic [ST_W-1:0] session_state;
    logic            tuning_required;
    logic            pid_update_required;
    logic            close_requested;
    logic            config_valid;
  } pfc_out_t;

endpackage

>>> design/pfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pid_filter_table_with_pending_changes.sv
// Top level of the PID filter table with pending adds and deletes.
//
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) carries one
// item with an opcode and a PID; each item gives exactly one result item on
// the output channel (out_valid_o, out_ready_i, out_data_o), in order.
// The block works on one item at a time and drops in_ready_o while busy.
// Add and delete scan the PID RAM slot by slot (address, then compare of the
// registered read data) and stop at the first match, then run the pending
// sweep over all slots when a mark changed.
// Delete-all and a committing settle sweep the marks once, and delete-all
// may add the pending sweep. Tuning changed, close, clear and the other
// settle cases go straight from the execute state to the result.
// in_ready_o returns once the sequencer is back in idle after the result
// is loaded.
// Reset marks every slot free and sets the session status to incomplete;
// the PID RAM is not cleared, since a free slot's PID is never compared.
// Results sit in an output register; a stalled receiver holds the finished
// result there and the next item waits in its last state until it drains.
module pid_filter_table_with_pending_changes #(
  parameter int unsigned NUM_SLOTS = pfc_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfc_pkg::pfc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfc_pkg::pfc_out_t out_data_o
);

  import pfc_pkg::*;

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_PEND  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [PID_W-1:0] pid_q, pid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] match_q, match_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] free_q, free_d;
  logic             free_ok_q, free_ok_d;
  logic             changed_q, changed_d;
  logic             pend_q, pend_d;
  logic [RC_W-1:0]  rc_q, rc_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic             out_valid_q, out_valid_d;
  pfc_out_t         out_data_q, out_data_d;

  logic [MK_W-1:0]  slot_mark_q [NUM_SLOTS];

  // Mark write controls.
  logic             mk_clr;
  logic             mk_we;
  logic [IDX_W-1:0] mk_widx;
  logic [MK_W-1:0]  mk_wdata;

  // PID RAM controls.
  logic             ram_we;
  logic [PID_W-1:0] ram_rdata;

  logic [MK_W-1:0]  cur_mark;
  logic [MK_W-1:0]  hit_mark;
  logic             last_idx;
  logic             any_pend;
  logic             out_load;

  assign cur_mark = slot_mark_q[idx_q];
  assign hit_mark = slot_mark_q[match_q];
  assign last_idx = (idx_q == IDX_LAST);
  assign any_pend = pend_q || (cur_mark == MK_ADD) || (cur_mark == MK_DEL);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // PID storage, read one slot at a time by the scan.
  pfc_ram #(
    .WIDTH (PID_W),
    .DEPTH (NUM_SLOTS)
  ) u_pid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_q),
    .wdata_i (pid_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer and per-item bookkeeping.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pid_d     = pid_q;
    idx_d     = idx_q;
    match_d   = match_q;
    found_d   = found_q;
    free_d    = free_q;
    free_ok_d = free_ok_q;
    changed_d = changed_q;
    pend_d    = pend_q;
    rc_d      = rc_q;
    status_d  = status_q;
    mk_clr    = 1'b0;
    mk_we     = 1'b0;
    mk_widx   = idx_q;
    mk_wdata  = MK_FREE;
    ram_we    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.opcode;
          pid_d     = in_data_i.pid_value;
          idx_d     = '0;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          changed_d = 1'b0;
          pend_d    = 1'b0;
          rc_d      = RC_OK;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_ADD, OP_DEL: begin
            state_d = S_RD;
          end
          OP_DEL_ALL: begin
            state_d = S_SWEEP;
          end
          OP_SETTLE: begin
            if (status_q == ST_TUNING || status_q == ST_PIDS) begin
              state_d = S_SWEEP;
            end else if (status_q != ST_SETTLED) begin
              rc_d = RC_ERROR;
            end
          end
          OP_TUNING: begin
            status_d = ST_TUNING;
          end
          OP_CLOSE: begin
            status_d = ST_CLOSING;
          end
          OP_CLEAR: begin
            status_d = ST_INCOMPLETE;
            mk_clr   = 1'b1;
          end
          default: begin
            rc_d = RC_NOCHANGE;
          end
        endcase
      end
      S_RD: begin
        // The RAM address is idx_q; data arrives next cycle.
        state_d = S_CMP;
      end
      S_CMP: begin
        if (cur_mark != MK_FREE && ram_rdata == pid_q) begin
          found_d = 1'b1;
          match_d = idx_q;
          state_d = S_ACT;
        end else begin
          if (cur_mark == MK_FREE && !free_ok_q) begin
            free_ok_d = 1'b1;
            free_d    = idx_q;
          end
          if (last_idx) begin
            state_d = S_ACT;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_ACT: begin
        mk_widx = match_q;
        if (op_q == OP_ADD) begin
          if (found_q) begin
            if (hit_mark == MK_DEL) begin
              mk_we     = 1'b1;
              mk_wdata  = MK_VALID;
              changed_d = 1'b1;
            end else begin
              rc_d = RC_NOCHANGE;
            end
          end else if (free_ok_q) begin
            mk_we     = 1'b1;
            mk_widx   = free_q;
            mk_wdata  = MK_ADD;
            ram_we    = 1'b1;
            changed_d = 1'b1;
          end else begin
            rc_d = RC_ERROR;
          end
        end else if (found_q) begin
          // Delete of a present PID.
          if (hit_mark == MK_DEL) begin
            rc_d = RC_NOCHANGE;
          end else begin
            mk_we     = 1'b1;
            mk_wdata  = (hit_mark == MK_VALID) ? MK_DEL : MK_FREE;
            changed_d = 1'b1;
          end
        end
        idx_d   = '0;
        state_d = (changed_d) ? S_PEND : S_DONE;
      end
      S_SWEEP: begin
        // One slot a cycle: delete-all or commit of pending changes.
        if (op_q == OP_DEL_ALL) begin
          if (cur_mark == MK_VALID) begin
            mk_we     = 1'b1;
            mk_wdata  = MK_DEL;
            changed_d = 1'b1;
          end else if (cur_mark == MK_ADD) begin
            mk_we     = 1'b1;
            mk_wdata  = MK_FREE;
            changed_d = 1'b1;
          end
        end else begin
          if (cur_mark == MK_ADD) begin
            mk_we    = 1'b1;
            mk_wdata = MK_VALID;
          end else if (cur_mark == MK_DEL) begin
            mk_we    = 1'b1;
            mk_wdata = MK_FREE;
          end
        end
        if (last_idx) begin
          idx_d = '0;
          if (op_q == OP_DEL_ALL) begin
            state_d = (changed_d) ? S_PEND : S_DONE;
          end else begin
            status_d = ST_SETTLED;
            state_d  = S_DONE;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_PEND: begin
        // Look for any pending slot, then let the status follow.
        pend_d = any_pend;
        if (last_idx) begin
          if (status_q == ST_SETTLED && any_pend) begin
            status_d = ST_PIDS;
          end else if (status_q == ST_PIDS && !any_pend) begin
            status_d = ST_SETTLED;
          end
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register contents.
  always_comb begin
    out_data_d                     = out_data_q;
    out_valid_d                    = out_valid_q;
    if (out_load) begin
      out_valid_d                    = 1'b1;
      out_data_d.result_code         = rc_q;
      out_data_d.session_state       = status_q;
      out_data_d.tuning_required     = (status_q == ST_TUNING);
      out_data_d.pid_update_required = (status_q == ST_PIDS);
      out_data_d.close_requested     = (status_q == ST_CLOSING);
      out_data_d.config_valid        = (status_q != ST_INCOMPLETE);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_INCOMPLETE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pid_q      <= pid_d;
    idx_q      <= idx_d;
    match_q    <= match_d;
    found_q    <= found_d;
    free_q     <= free_d;
    free_ok_q  <= free_ok_d;
    changed_q  <= changed_d;
    pend_q     <= pend_d;
    rc_q       <= rc_d;
    out_data_q <= out_data_d;
  end

  // Slot marks: cleared together at reset and on clear, else one write a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_mark_q[i] <= MK_FREE;
      end
    end else if (mk_clr) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_mark_q[i] <= MK_FREE;
      end
    end else if (mk_we) begin
      slot_mark_q[mk_widx] <= mk_wdata;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready right after accepting an item");

  // The stored session status never leaves the defined codes.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q <= ST_CLOSING)
    else $error("session status outside defined codes");

  // The slot index never runs past the last slot.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_SWEEP || state_q == S_PEND) |-> idx_q <= IDX_LAST)
    else $error("slot index past the table");

  // A result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result overwritten or dropped");

  // The pid-update and config-valid flags of a result agree with its session state.
  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pid_update_required == (out_data_o.session_state == ST_PIDS))
      && (out_data_o.config_valid == (out_data_o.session_state != ST_INCOMPLETE)))
    else $error("result flags disagree with session state");

endmodule
